// ----- rtl/core/normal_frame_momentum_rotation_defines.svh -----
// assertion macros for the normal frame momentum rotation block
`ifndef NORMAL_FRAME_MOMENTUM_ROTATION_DEFINES_SVH
`define NORMAL_FRAME_MOMENTUM_ROTATION_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define NFMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfmr check failed");

// next-cycle implication, checked on clk outside reset
`define NFMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfmr check failed");

`endif

// ----- rtl/core/nfmr_pkg.sv -----
// shared types and constants for the normal frame momentum rotation block
`timescale 1ns / 1ps
package nfmr_pkg;

  localparam int CP_W   = 31;  // cos psi, q2.30 magnitude up to 1.0
  localparam int RAD_W  = 61;  // radicand, q1.60 up to 1.0
  localparam int SQ_LAT = 31;  // one root bit per stage
  localparam int DIV_QB = 33;  // quotient bits before saturation
  localparam int DIV_LAT = DIV_QB + 2;
  localparam int CW     = 33;  // coefficient width, q2.30 plus headroom

  localparam logic [1:0] DIMS_THRU0 = 2'd0;  // pass-through code
  localparam logic [1:0] DIMS_THRU1 = 2'd1;  // pass-through code
  localparam logic [1:0] DIMS_2D = 2'd2;
  localparam logic [1:0] DIMS_3D = 2'd3;
  localparam logic       ACT_FWD = 1'b0;
  localparam logic       ACT_INV = 1'b1;

  localparam logic [CP_W-1:0]        COS_EPS = 31'd1074;
  localparam logic signed [31:0]     Q30_ONE = 32'sd1073741824;
  localparam logic signed [CW-1:0]   C_ONE   = 33'sd1073741824;

  typedef struct packed {
    logic              act;
    logic [1:0]        dims;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
  } side_t;

  // q2.30 product, rounded half up
  function automatic logic signed [CW-1:0] mul_round(input logic signed [63:0] p);
    logic signed [64:0] t;
    begin
      t = 65'(p) + 65'sd536870912;
      t = t >>> 30;
      return t[CW-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/nfmr_sqrt.sv -----
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module nfmr_sqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [nfmr_pkg::RAD_W-1:0] rad,
  output logic [nfmr_pkg::CP_W-1:0]  root
);
  import nfmr_pkg::*;

  localparam int SW = RAD_W + 1;

  logic [SW-1:0] rem_r [SQ_LAT];
  logic [SW-1:0] acc_r [SQ_LAT];

  for (genvar s = 0; s < SQ_LAT; s++) begin : g_stage
    localparam int BP = 2 * (SQ_LAT - 1 - s);
    logic [SW-1:0] rem_in;
    logic [SW-1:0] acc_in;
    logic [SW-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in = SW'(rad);
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign acc_in = acc_r[s-1];
    end

    assign trial = acc_in + (SW'(1) << BP);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          acc_r[s] <= (acc_in >> 1) + (SW'(1) << BP);
        end else begin
          rem_r[s] <= rem_in;
          acc_r[s] <= acc_in >> 1;
        end
      end
    end
  end

  assign root = acc_r[SQ_LAT-1][CP_W-1:0];

endmodule

// ----- rtl/core/nfmr_div.sv -----
// pipelined rounded q2.30 ratio num / den, saturated to 32 bits
`timescale 1ns / 1ps
module nfmr_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [31:0]        num,
  input  logic [nfmr_pkg::CP_W-1:0] den,
  output logic signed [31:0]        quo
);
  import nfmr_pkg::*;

  localparam int DW = 64;

  logic [31:0]     mag;
  logic [DW-1:0]   nval_r;
  logic [CP_W-1:0] den_p_r;
  logic            neg_p_r;

  logic [DW-1:0]     rem_r [DIV_QB];
  logic [DIV_QB-1:0] q_r   [DIV_QB];
  logic [CP_W-1:0]   den_r [DIV_QB];
  logic              neg_r [DIV_QB];
  logic              ovf_r [DIV_QB];

  logic [DIV_QB-1:0] q_fin;
  logic signed [31:0] quo_r;

  assign mag = num[31] ? (~num + 32'd1) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      nval_r  <= (DW'(mag) << 30) + DW'(den >> 1);
      den_p_r <= den;
      neg_p_r <= num[31];
    end
  end

  for (genvar s = 0; s < DIV_QB; s++) begin : g_stage
    localparam int SH = DIV_QB - 1 - s;
    logic [DW-1:0]     rem_in;
    logic [DIV_QB-1:0] q_in;
    logic [CP_W-1:0]   den_in;
    logic              neg_in;
    logic              ovf_in;
    logic [DW-1:0]     dsh;

    if (s == 0) begin : g_first
      assign rem_in = nval_r;
      assign q_in   = '0;
      assign den_in = den_p_r;
      assign neg_in = neg_p_r;
      // quotient would need more than DIV_QB bits
      assign ovf_in = nval_r >= (DW'(den_p_r) << DIV_QB);
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign den_in = den_r[s-1];
      assign neg_in = neg_r[s-1];
      assign ovf_in = ovf_r[s-1];
    end

    assign dsh = DW'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        neg_r[s] <= neg_in;
        ovf_r[s] <= ovf_in;
        if (rem_in >= dsh) begin
          rem_r[s] <= rem_in - dsh;
          q_r[s]   <= q_in | (DIV_QB'(1) << SH);
        end else begin
          rem_r[s] <= rem_in;
          q_r[s]   <= q_in;
        end
      end
    end
  end

  assign q_fin = q_r[DIV_QB-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[DIV_QB-1]) begin
        if (ovf_r[DIV_QB-1] || q_fin > DIV_QB'(33'h0_8000_0000)) begin
          quo_r <= 32'sh8000_0000;
        end else begin
          quo_r <= -signed'(q_fin[31:0]);
        end
      end else begin
        if (ovf_r[DIV_QB-1] || q_fin > DIV_QB'(33'h0_7FFF_FFFF)) begin
          quo_r <= 32'sh7FFF_FFFF;
        end else begin
          quo_r <= signed'(q_fin[31:0]);
        end
      end
    end
  end

  assign quo = quo_r;

endmodule

// ----- rtl/core/normal_frame_momentum_rotation.sv -----
// top level: rotates a momentum vector into or out of a face normal frame
// usage:
//   input beats carry action, the q2.30 normal and the q16.16 momentum; each
//   accepted beat gives exactly one result beat with the rotated momentum and
//   a saturated flag, in order.
//   cfg_we / cfg_wdata write space_dims (2 = planar, 3 = full 3d, other codes
//   pass the momentum through); write only while the block is drained.
// pipeline: from the accepting edge to out_valid the chain is
//   entry, nz squared, radicand, a 31-stage square root, a 35-stage divider
//   for sin/cos theta, coefficient products, matrix build, nine momentum
//   products, row sums and round/saturate, then the output register.
// throughput: one beat per cycle while in_stall is low; every stage is a register stage.
// stall: when out_stall holds a result, the next result goes to a skid
//   register; only when the skid is full does in_stall rise and the whole
//   pipeline freeze, so nothing is dropped or repeated.
// reset: synchronous, active low; clears all valid bits, empties the output
//   and skid registers and sets space_dims to 3. no clearing pass is needed.
`timescale 1ns / 1ps
module normal_frame_momentum_rotation #(
  parameter int MOM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [31:0] in_nor_x,
  input  logic signed [31:0] in_nor_y,
  input  logic signed [31:0] in_nor_z,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic               out_saturated
);
  import nfmr_pkg::*;

  `include "normal_frame_momentum_rotation_defines.svh"

  // stage positions along the pipe
  localparam int P_CP   = 2 + SQ_LAT;
  localparam int P_Q    = P_CP + DIV_LAT;
  localparam int P_MUL  = P_Q + 1;
  localparam int P_COEF = P_MUL + 1;
  localparam int P_PROD = P_COEF + 1;
  localparam int P_SUM  = P_PROD + 1;
  localparam int P_OUT  = P_SUM + 1;

  localparam int PW = CW + 32;
  localparam int SW = PW + 2;
  localparam int XW = 72;

  localparam logic signed [XW-1:0] SAT_MAX = (XW'(1) <<< (MOM_WIDTH - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_MIN = -SAT_MAX - XW'(1);
  localparam logic signed [63:0]   R_ONE   = 64'sd1 <<< 60;

  logic [1:0] dims_r;
  logic       en;

  logic  v_r    [P_OUT+1];
  side_t side_r [P_COEF+1];

  logic signed [63:0] sq_r;
  logic [RAD_W-1:0]   rad_r;
  logic [CP_W-1:0]    cp_w;
  logic [CP_W-1:0]    cpd_r [DIV_LAT];
  logic signed [31:0] st_q, ct_q;

  logic               eps_ok;
  logic signed [31:0] st_sel, ct_sel;
  logic signed [31:0] st_r, ct_r;
  logic [CP_W-1:0]    cp_r;
  logic signed [63:0] pcc_r, pcs_r, psc_r, pss_r;

  logic signed [CW-1:0] coef_nxt [3][3];
  logic signed [CW-1:0] coef_r   [3][3];
  logic signed [PW-1:0] prod_r   [3][3];
  logic signed [SW-1:0] sum_r    [3];
  logic signed [31:0]   rot_nxt  [3];
  logic signed [31:0]   rot_r    [3];
  logic                 sat_nxt, sat_r;

  logic               out_valid_r, skid_v_r;
  logic signed [31:0] out_rot_r [3];
  logic signed [31:0] skid_rot_r [3];
  logic               out_sat_r, skid_sat_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_3D;
    end else if (cfg_we) begin
      dims_r <= cfg_wdata;
    end
  end

  // pipe advances unless the skid register is holding a beat
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= P_OUT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= P_OUT; k++) v_r[k] <= v_r[k-1];
    end
  end

  // side data travels with the beat up to the product stage
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{act: in_action, dims: dims_r, nx: in_nor_x, ny: in_nor_y,
                     nz: in_nor_z, mx: in_mom_x, my: in_mom_y, mz: in_mom_z};
      for (int k = 1; k <= P_COEF; k++) side_r[k] <= side_r[k-1];
    end
  end

  // sin psi squared, then 1 - sin^2 clamped at zero
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= 64'(side_r[0].nz) * 64'(side_r[0].nz);
      rad_r <= (sq_r >= R_ONE) ? '0 : RAD_W'(R_ONE - sq_r);
    end
  end

  nfmr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (cp_w)
  );

  // sin theta and cos theta dividers run side by side
  nfmr_div u_div_st (
    .clk (clk),
    .en  (en),
    .num (side_r[P_CP].ny),
    .den (cp_w),
    .quo (st_q)
  );

  nfmr_div u_div_ct (
    .clk (clk),
    .en  (en),
    .num (side_r[P_CP].nx),
    .den (cp_w),
    .quo (ct_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cpd_r[0] <= cp_w;
      for (int k = 1; k < DIV_LAT; k++) cpd_r[k] <= cpd_r[k-1];
    end
  end

  // near the poles theta is pinned: sin 1, cos 0
  assign eps_ok = cpd_r[DIV_LAT-1] >= COS_EPS;
  assign st_sel = eps_ok ? st_q : Q30_ONE;
  assign ct_sel = eps_ok ? ct_q : 32'sd0;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_sel;
      ct_r  <= ct_sel;
      cp_r  <= cpd_r[DIV_LAT-1];
      pcc_r <= 64'(signed'({1'b0, cpd_r[DIV_LAT-1]})) * 64'(ct_sel);
      pcs_r <= 64'(signed'({1'b0, cpd_r[DIV_LAT-1]})) * 64'(st_sel);
      psc_r <= 64'(side_r[P_Q].nz) * 64'(ct_sel);
      pss_r <= 64'(side_r[P_Q].nz) * 64'(st_sel);
    end
  end

  // rotation matrix build
  always_comb begin
    logic signed [CW-1:0] mcc, mcs, msc, mss, st, ct, cp, nx, ny, nz;
    mcc = mul_round(pcc_r);
    mcs = mul_round(pcs_r);
    msc = mul_round(psc_r);
    mss = mul_round(pss_r);
    st  = CW'(st_r);
    ct  = CW'(ct_r);
    cp  = CW'(signed'({1'b0, cp_r}));
    nx  = CW'(side_r[P_MUL].nx);
    ny  = CW'(side_r[P_MUL].ny);
    nz  = CW'(side_r[P_MUL].nz);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) coef_nxt[i][j] = (i == j) ? C_ONE : '0;
    end
    case (side_r[P_MUL].dims)
      DIMS_2D: begin
        coef_nxt[0][0] = nx;
        coef_nxt[1][1] = nx;
        if (side_r[P_MUL].act == ACT_FWD) begin
          coef_nxt[0][1] = ny;
          coef_nxt[1][0] = -ny;
        end else begin
          coef_nxt[0][1] = -ny;
          coef_nxt[1][0] = ny;
        end
      end
      DIMS_3D: begin
        coef_nxt[0][0] = mcc;
        coef_nxt[1][1] = ct;
        coef_nxt[2][2] = cp;
        if (side_r[P_MUL].act == ACT_FWD) begin
          coef_nxt[0][1] = mcs;
          coef_nxt[0][2] = nz;
          coef_nxt[1][0] = -st;
          coef_nxt[1][2] = '0;
          coef_nxt[2][0] = -msc;
          coef_nxt[2][1] = -mss;
        end else begin
          coef_nxt[0][1] = -st;
          coef_nxt[0][2] = -msc;
          coef_nxt[1][0] = mcs;
          coef_nxt[1][2] = -mss;
          coef_nxt[2][0] = nz;
          coef_nxt[2][1] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= coef_nxt;
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= PW'(coef_r[i][0]) * PW'(side_r[P_COEF].mx);
        prod_r[i][1] <= PW'(coef_r[i][1]) * PW'(side_r[P_COEF].my);
        prod_r[i][2] <= PW'(coef_r[i][2]) * PW'(side_r[P_COEF].mz);
        sum_r[i] <= SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2])
                    + SW'(536870912);
      end
    end
  end

  // round to q16.16 and clip to the momentum width
  always_comb begin
    logic signed [SW-1:0] sh;
    logic signed [XW-1:0] ext;
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sh  = sum_r[i] >>> 30;
      ext = XW'(sh);
      if (ext > SAT_MAX) begin
        ext     = SAT_MAX;
        sat_nxt = 1'b1;
      end else if (ext < SAT_MIN) begin
        ext     = SAT_MIN;
        sat_nxt = 1'b1;
      end
      rot_nxt[i] = ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  // output register plus one skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= v_r[P_OUT];
      end
    end else if (en && v_r[P_OUT]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_rot_r <= skid_rot_r;
        out_sat_r <= skid_sat_r;
      end else begin
        out_rot_r <= rot_r;
        out_sat_r <= sat_r;
      end
    end else if (en) begin
      skid_rot_r <= rot_r;
      skid_sat_r <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rot_x     = out_rot_r[0];
  assign out_rot_y     = out_rot_r[1];
  assign out_rot_z     = out_rot_r[2];
  assign out_saturated = out_sat_r;

  // skid only fills behind a held output beat
  `NFMR_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_valid_r)
  // a taken output empties the skid in the next cycle
  `NFMR_ASSERT_NEXT(a_skid_drains, skid_v_r && !out_stall, !skid_v_r)
  // a beat leaving the pipe into a held output lands in the skid
  `NFMR_ASSERT_NEXT(a_skid_catches,
                    v_r[P_OUT] && !skid_v_r && out_valid_r && out_stall, skid_v_r)

endmodule
